@@ sv/pnz_pkg.sv @@
// Shared constants and types for the Perlin noise sampler.
`default_nettype none
package pnz_pkg;

   localparam int ONE_Q16   = 65536;
   localparam int TAB_DEPTH = 257;
   localparam int TAB_AW    = 9;
   localparam int TAB_DW    = 8;
   localparam int FADE_W    = 17;
   localparam int CSR_DW    = 24;
   localparam int CSR_AW    = 3;

   typedef enum logic [CSR_AW-1:0] {
      CSR_OFFSET_X  = 3'd0,
      CSR_OFFSET_Y  = 3'd1,
      CSR_OFFSET_Z  = 3'd2,
      CSR_ZERO_FRAC = 3'd3,
      CSR_ZERO_CELL = 3'd4,
      CSR_ZERO_FADE = 3'd5
   } csr_index_type;

endpackage
`default_nettype wire

@@ sv/perlin_noise_3d_sampler_core.sv @@
// Top level of the pipelined 3D Perlin noise sampler.
//
// Usage:
//  - req channel (valid/ready) carries sample beats (req_mode 0, coordinates) and
//    table load beats (req_mode 1, req_table_index, req_table_value).
//  - rsp channel (valid/ready) returns one noise value per sample beat, in order;
//    load beats return nothing.
//  - csr port writes offsets and zero-y registers; write only while idle.
//  - Throughput: one beat per cycle while the receiver does not stall. A sample
//    beat passes three dependent permutation-table lookups (each a registered
//    read of replicated table RAMs), the fade multiplier chain and three
//    interpolation stages.
//  - The table is held in 14 RAM copies (2, 4 and 8 per lookup level); a load beat
//    writes each level as it passes that level, so table order follows beat order.
//  - When the receiver stalls, the whole pipeline and RAM read registers hold, and
//    req_ready drops until the waiting result beat is taken.
//  - Reset clears configuration and pipeline valid bits; the table is undefined
//    until loaded.
`default_nettype none
module perlin_noise_3d_sampler_core #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_mode,
   input  wire logic signed [47:0]           req_coord_x,
   input  wire logic signed [47:0]           req_coord_y,
   input  wire logic signed [47:0]           req_coord_z,
   input  wire logic [8:0]                   req_table_index,
   input  wire logic [7:0]                   req_table_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [17:0]                rsp_noise_value,
   input  wire logic                         csr_we,
   input  wire logic [pnz_pkg::CSR_AW-1:0]   csr_index,
   input  wire logic [pnz_pkg::CSR_DW-1:0]   csr_wdata
);
   import pnz_pkg::*;

   localparam int F = COORD_FRAC_BITS;

   // Gradient select over the sixteen hash cases
   function automatic logic signed [18:0] grad_sum(input logic [3:0] h,
                                                   input logic signed [17:0] a,
                                                   input logic signed [17:0] b,
                                                   input logic signed [17:0] c);
      logic signed [18:0] ea;
      logic signed [18:0] eb;
      logic signed [18:0] ec;
      logic signed [18:0] r;
      ea = 19'(a);
      eb = 19'(b);
      ec = 19'(c);
      case (h)
         4'd0:    r =  ea + eb;
         4'd1:    r = -ea + eb;
         4'd2:    r =  ea - eb;
         4'd3:    r = -ea - eb;
         4'd4:    r =  ea + ec;
         4'd5:    r = -ea + ec;
         4'd6:    r =  ea - ec;
         4'd7:    r = -ea - ec;
         4'd8:    r =  eb + ec;
         4'd9:    r = -eb + ec;
         4'd10:   r =  eb - ec;
         4'd11:   r = -eb - ec;
         4'd12:   r =  ea + eb;
         4'd13:   r = -eb + ec;
         4'd14:   r = -ea + eb;
         default: r = -eb - ec;
      endcase
      return r;
   endfunction

   // Linear blend p + floor(t*(q-p))
   function automatic logic signed [18:0] blend(input logic [FADE_W-1:0] t,
                                                input logic signed [18:0] p,
                                                input logic signed [18:0] q);
      logic signed [19:0] d;
      logic signed [37:0] prod;
      logic signed [19:0] s;
      d    = 20'(q) - 20'(p);
      prod = 38'($signed({1'b0, t})) * 38'(d);
      s    = 20'(p) + prod[35:16];
      return s[18:0];
   endfunction

   // Configuration registers
   logic [23:0]       offset_x_ff;
   logic [23:0]       offset_y_ff;
   logic [23:0]       offset_z_ff;
   logic [15:0]       zero_y_fraction_ff;
   logic [7:0]        zero_y_cell_ff;
   logic [16:0]       zero_y_fade_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff        <= '0;
         offset_y_ff        <= '0;
         offset_z_ff        <= '0;
         zero_y_fraction_ff <= '0;
         zero_y_cell_ff     <= '0;
         zero_y_fade_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OFFSET_X:  offset_x_ff        <= csr_wdata;
            CSR_OFFSET_Y:  offset_y_ff        <= csr_wdata;
            CSR_OFFSET_Z:  offset_z_ff        <= csr_wdata;
            CSR_ZERO_FRAC: zero_y_fraction_ff <= csr_wdata[15:0];
            CSR_ZERO_CELL: zero_y_cell_ff     <= csr_wdata[7:0];
            CSR_ZERO_FADE: zero_y_fade_ff     <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // Global advance: move when the output register is free or being taken
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Coordinate split
   logic signed [48:0] sx;
   logic signed [48:0] sy;
   logic signed [48:0] sz;
   logic [15:0]        fx_c;
   logic [15:0]        fy_c;
   logic [15:0]        fz_c;
   logic               y_zero;

   always_comb begin
      sx     = 49'(req_coord_x) + $signed({25'b0, offset_x_ff});
      sy     = 49'(req_coord_y) + $signed({25'b0, offset_y_ff});
      sz     = 49'(req_coord_z) + $signed({25'b0, offset_z_ff});
      y_zero = (req_coord_y == '0);
   end

   if (F >= 16) begin : g_frac_down
      assign fx_c = sx[F-1 -: 16];
      assign fy_c = sy[F-1 -: 16];
      assign fz_c = sz[F-1 -: 16];
   end else begin : g_frac_up
      assign fx_c = 16'(sx[F-1:0]) << (16 - F);
      assign fy_c = 16'(sy[F-1:0]) << (16 - F);
      assign fz_c = 16'(sz[F-1:0]) << (16 - F);
   end

   // Stage 1: registered cells, fractions and load beat
   logic              v1_ff, load1_ff, yz1_ff;
   logic [8:0]        lidx1_ff;
   logic [7:0]        lval1_ff;
   logic [7:0]        hx1_ff, hy1_ff, hz1_ff;
   logic [15:0]       fx1_ff, fy1_ff, fz1_ff;

   // Stage 2 and 3 registers
   logic              v2_ff, load2_ff, yz2_ff;
   logic [8:0]        lidx2_ff;
   logic [7:0]        lval2_ff;
   logic [7:0]        hy2_ff, hz2_ff;
   logic [15:0]       fx2_ff, fy2_ff, fz2_ff;
   logic              v3_ff, load3_ff, yz3_ff;
   logic [8:0]        lidx3_ff;
   logic [7:0]        lval3_ff;
   logic [7:0]        hz3_ff;
   logic [15:0]       fx3_ff, fy3_ff, fz3_ff;

   // Stage 4 onward: sample beats only
   logic              sv4_ff, yz4_ff;
   logic [15:0]       fx4_ff, fy4_ff, fz4_ff;
   logic              sv5_ff, sv6_ff, sv7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         sv4_ff       <= 1'b0;
         sv5_ff       <= 1'b0;
         sv6_ff       <= 1'b0;
         sv7_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         sv4_ff       <= v3_ff && !load3_ff;
         sv5_ff       <= sv4_ff;
         sv6_ff       <= sv5_ff;
         sv7_ff       <= sv6_ff;
         rsp_valid_ff <= sv7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         load1_ff <= req_mode;
         lidx1_ff <= req_table_index;
         lval1_ff <= req_table_value;
         yz1_ff   <= y_zero;
         hx1_ff   <= sx[F+7:F];
         hy1_ff   <= y_zero ? zero_y_cell_ff : sy[F+7:F];
         hz1_ff   <= sz[F+7:F];
         fx1_ff   <= fx_c;
         fy1_ff   <= y_zero ? zero_y_fraction_ff : fy_c;
         fz1_ff   <= fz_c;

         load2_ff <= load1_ff;
         lidx2_ff <= lidx1_ff;
         lval2_ff <= lval1_ff;
         yz2_ff   <= yz1_ff;
         hy2_ff   <= hy1_ff;
         hz2_ff   <= hz1_ff;
         fx2_ff   <= fx1_ff;
         fy2_ff   <= fy1_ff;
         fz2_ff   <= fz1_ff;

         load3_ff <= load2_ff;
         lidx3_ff <= lidx2_ff;
         lval3_ff <= lval2_ff;
         yz3_ff   <= yz2_ff;
         hz3_ff   <= hz2_ff;
         fx3_ff   <= fx2_ff;
         fy3_ff   <= fy2_ff;
         fz3_ff   <= fz2_ff;

         yz4_ff   <= yz3_ff;
         fx4_ff   <= fx3_ff;
         fy4_ff   <= fy3_ff;
         fz4_ff   <= fz3_ff;
      end
   end

   // Table writes per level, as the load beat passes that level
   logic we1, we2, we3;
   assign we1 = en && v1_ff && load1_ff && (lidx1_ff <= 9'(TAB_DEPTH - 1));
   assign we2 = en && v2_ff && load2_ff && (lidx2_ff <= 9'(TAB_DEPTH - 1));
   assign we3 = en && v3_ff && load3_ff && (lidx3_ff <= 9'(TAB_DEPTH - 1));

   // Level 1 lookups: hx, hx+1
   logic [TAB_AW-1:0] ra1 [2];
   logic [TAB_DW-1:0] rd1 [2];
   assign ra1[0] = {1'b0, hx1_ff};
   assign ra1[1] = 9'(hx1_ff) + 9'd1;

   for (genvar i = 0; i < 2; i++) begin : g_l1
      pnz_ram #(.WIDTH(TAB_DW), .DEPTH(TAB_DEPTH)) u_ram (
         .clock (clock), .we (we1), .waddr (lidx1_ff), .wdata (lval1_ff),
         .re (en), .raddr (ra1[i]), .rdata (rd1[i])
      );
   end

   // Level 2 lookups: a0, a0+1, a1, a1+1
   logic [7:0]        a0, a1;
   logic [TAB_AW-1:0] ra2 [4];
   logic [TAB_DW-1:0] rd2 [4];
   assign a0     = rd1[0] + hy2_ff;
   assign a1     = rd1[1] + hy2_ff;
   assign ra2[0] = {1'b0, a0};
   assign ra2[1] = 9'(a0) + 9'd1;
   assign ra2[2] = {1'b0, a1};
   assign ra2[3] = 9'(a1) + 9'd1;

   for (genvar i = 0; i < 4; i++) begin : g_l2
      pnz_ram #(.WIDTH(TAB_DW), .DEPTH(TAB_DEPTH)) u_ram (
         .clock (clock), .we (we2), .waddr (lidx2_ff), .wdata (lval2_ff),
         .re (en), .raddr (ra2[i]), .rdata (rd2[i])
      );
   end

   // Level 3 lookups: corner hashes b00, b10, b01, b11 and their +1 neighbours
   logic [7:0]        b00, b01, b10, b11;
   logic [TAB_AW-1:0] ra3 [8];
   logic [TAB_DW-1:0] rd3 [8];
   assign b00    = rd2[0] + hz3_ff;
   assign b01    = rd2[1] + hz3_ff;
   assign b10    = rd2[2] + hz3_ff;
   assign b11    = rd2[3] + hz3_ff;
   assign ra3[0] = {1'b0, b00};
   assign ra3[1] = 9'(b00) + 9'd1;
   assign ra3[2] = {1'b0, b10};
   assign ra3[3] = 9'(b10) + 9'd1;
   assign ra3[4] = {1'b0, b01};
   assign ra3[5] = 9'(b01) + 9'd1;
   assign ra3[6] = {1'b0, b11};
   assign ra3[7] = 9'(b11) + 9'd1;

   for (genvar i = 0; i < 8; i++) begin : g_l3
      pnz_ram #(.WIDTH(TAB_DW), .DEPTH(TAB_DEPTH)) u_ram (
         .clock (clock), .we (we3), .waddr (lidx3_ff), .wdata (lval3_ff),
         .re (en), .raddr (ra3[i]), .rdata (rd3[i])
      );
   end

   // Fade weights, aligned with stage 4
   logic [FADE_W-1:0] tx4, ty4_c, tz4, ty4;

   pnz_fade u_fade_x (.clock (clock), .en (en), .u (fx1_ff), .t (tx4));
   pnz_fade u_fade_y (.clock (clock), .en (en), .u (fy1_ff), .t (ty4_c));
   pnz_fade u_fade_z (.clock (clock), .en (en), .u (fz1_ff), .t (tz4));

   assign ty4 = !yz4_ff ? ty4_c :
                (zero_y_fade_ff > 17'(ONE_Q16)) ? FADE_W'(ONE_Q16) : zero_y_fade_ff;

   // Stage 5: corner gradients
   logic signed [17:0] xn, xf, yn, yf, zn, zf;
   logic signed [18:0] g5_ff [8];
   logic [FADE_W-1:0]  tx5_ff, ty5_ff, tz5_ff;

   assign xn = $signed({2'b00, fx4_ff});
   assign xf = $signed({2'b11, fx4_ff});
   assign yn = $signed({2'b00, fy4_ff});
   assign yf = $signed({2'b11, fy4_ff});
   assign zn = $signed({2'b00, fz4_ff});
   assign zf = $signed({2'b11, fz4_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         g5_ff[0] <= grad_sum(rd3[0][3:0], xn, yn, zn);
         g5_ff[1] <= grad_sum(rd3[1][3:0], xn, yn, zf);
         g5_ff[2] <= grad_sum(rd3[2][3:0], xf, yn, zn);
         g5_ff[3] <= grad_sum(rd3[3][3:0], xf, yn, zf);
         g5_ff[4] <= grad_sum(rd3[4][3:0], xn, yf, zn);
         g5_ff[5] <= grad_sum(rd3[5][3:0], xn, yf, zf);
         g5_ff[6] <= grad_sum(rd3[6][3:0], xf, yf, zn);
         g5_ff[7] <= grad_sum(rd3[7][3:0], xf, yf, zf);
         tx5_ff   <= tx4;
         ty5_ff   <= ty4;
         tz5_ff   <= tz4;
      end
   end

   // Stages 6 to 8: blend along x, y, then z and saturate
   logic signed [18:0] m6_ff [4];
   logic signed [18:0] n7_ff [2];
   logic [FADE_W-1:0]  ty6_ff, tz6_ff, tz7_ff;
   logic signed [18:0] v_z;
   logic signed [17:0] noise_in;
   logic signed [17:0] rsp_noise_value_ff;

   always_comb begin
      v_z = blend(tz7_ff, n7_ff[0], n7_ff[1]);
      if (v_z > 19'sd131071) begin
         noise_in = 18'sd131071;
      end else if (v_z < -19'sd131072) begin
         noise_in = -18'sd131072;
      end else begin
         noise_in = v_z[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m6_ff[0]           <= blend(tx5_ff, g5_ff[0], g5_ff[2]);
         m6_ff[1]           <= blend(tx5_ff, g5_ff[4], g5_ff[6]);
         m6_ff[2]           <= blend(tx5_ff, g5_ff[1], g5_ff[3]);
         m6_ff[3]           <= blend(tx5_ff, g5_ff[5], g5_ff[7]);
         ty6_ff             <= ty5_ff;
         tz6_ff             <= tz5_ff;
         n7_ff[0]           <= blend(ty6_ff, m6_ff[0], m6_ff[1]);
         n7_ff[1]           <= blend(ty6_ff, m6_ff[2], m6_ff[3]);
         tz7_ff             <= tz6_ff;
         rsp_noise_value_ff <= noise_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

   // A load beat never enters the result stages
   assert property (@(posedge clock) disable iff (reset)
      (en && v3_ff && load3_ff) |=> !sv4_ff)
      else $error("load beat leaked into result pipeline");

   // Fade weights stay within one
   assert property (@(posedge clock) disable iff (reset)
      sv5_ff |-> (tx5_ff <= 17'(ONE_Q16) && ty5_ff <= 17'(ONE_Q16)
                  && tz5_ff <= 17'(ONE_Q16)))
      else $error("fade weight above one");

   // A zero y sample takes the configured cell
   assert property (@(posedge clock) disable iff (reset)
      (en && req_valid && !req_mode && req_coord_y == '0)
         |=> (yz1_ff && hy1_ff == zero_y_cell_ff))
      else $error("zero y cell not selected");

endmodule
`default_nettype wire

@@ sv/pnz_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pnz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 257
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, hold data while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ sv/pnz_fade.sv @@
// Three-stage quintic fade weight pipeline, Q0.16 in, Q1.16 out.
`default_nettype none
module pnz_fade (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [15:0]                  u,
   output logic      [pnz_pkg::FADE_W-1:0]   t
);
   import pnz_pkg::*;

   logic [19:0] diff;
   logic [35:0] prod_b;
   logic [31:0] prod_c;
   logic [19:0] b_in;
   logic [15:0] c_in;
   logic [15:0] u_ff;
   logic [19:0] b_ff;
   logic [15:0] c_ff;
   logic [31:0] prod_d;
   logic [15:0] d_in;
   logic [15:0] d_ff;
   logic [19:0] b2_ff;
   logic [35:0] prod_t;
   logic [19:0] t_raw;
   logic [FADE_W-1:0] t_in;
   logic [FADE_W-1:0] t_ff;

   // First stage: b = 10 - u*(15 - 6u), c = u*u
   always_comb begin
      diff   = 20'(15 * ONE_Q16) - 20'(u) * 20'd6;
      prod_b = 36'(u) * 36'(diff);
      b_in   = 20'(10 * ONE_Q16) - prod_b[35:16];
      prod_c = 32'(u) * 32'(u);
      c_in   = prod_c[31:16];
   end

   // Second stage: d = c*u
   always_comb begin
      prod_d = 32'(c_ff) * 32'(u_ff);
      d_in   = prod_d[31:16];
   end

   // Third stage: t = d*b, saturated to one
   always_comb begin
      prod_t = 36'(d_ff) * 36'(b2_ff);
      t_raw  = prod_t[35:16];
      t_in   = (t_raw > 20'(ONE_Q16)) ? FADE_W'(ONE_Q16) : t_raw[FADE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff  <= u;
         b_ff  <= b_in;
         c_ff  <= c_in;
         d_ff  <= d_in;
         b2_ff <= b_ff;
         t_ff  <= t_in;
      end
   end

   assign t = t_ff;

endmodule
`default_nettype wire
